[rtl/core/ubds_pkg.sv]
// ----------------------------------------------------------------------------
// ubds_pkg
// shared widths and constants for the baud divisor and oversampling search
// ----------------------------------------------------------------------------
package ubds_pkg;

    localparam int unsigned DATA_W   = 32;          // clock and baud words
    localparam int unsigned OSR_W    = 5;           // oversampling code
    localparam int unsigned RATIO_W  = OSR_W + 1;   // code + 1, up to 32
    localparam int unsigned PROD_W   = DATA_W + RATIO_W;
    localparam int unsigned REM_W    = PROD_W - 1;  // product stays below 2**37

    localparam int unsigned MAX_DIVISOR_DEF = 8191;

    localparam logic [DATA_W-1:0] CLOCK_HZ_RST = 32'd48000000;

    localparam logic [OSR_W-1:0] OSR_FIRST = 5'd31;
    localparam logic [OSR_W-1:0] OSR_LAST  = 5'd4;

    localparam int unsigned CNT_W = $clog2(DATA_W);

    typedef logic [DATA_W-1:0] word_t;

endpackage

[rtl/core/uart_baud_divisor_search.sv]
// ----------------------------------------------------------------------------
// uart_baud_divisor_search
// picks oversampling code and baud divisor nearest a requested baud rate
// ----------------------------------------------------------------------------
//
//  channel   signals                         direction  handshake
//  -------   ------------------------------  ---------  ------------------------
//  config    cfg_wr_en, cfg_wr_data          in         write on cfg_wr_en
//  request   in_valid/in_ready, baud_rate    in         valid and ready
//  result    out_valid/out_ready,            out        valid and ready
//            osr_code, divisor
//
//  each oversampling code, from 31 down to 4, takes one multiply and one
//  division for the base divisor, plus one multiply and one division per
//  divisor candidate tried (at most two per code); a zero baud rate skips
//  the search; one restoring divider is shared by every division
//  rst_n clears the sequencer and result valid and loads the 48 MHz clock
//  the next request is taken once the result sits in the output register;
//  a stalled result holds the sequencer in its final state
// ----------------------------------------------------------------------------
module uart_baud_divisor_search
#(
    parameter int unsigned MAX_DIVISOR = ubds_pkg::MAX_DIVISOR_DEF,
    localparam int unsigned DIV_W      = $clog2(MAX_DIVISOR + 1)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [ubds_pkg::DATA_W-1:0] cfg_wr_data,
    // request
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ubds_pkg::DATA_W-1:0] baud_rate,
    // result
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ubds_pkg::OSR_W-1:0] osr_code,
    output logic [DIV_W-1:0]           divisor
);

    import ubds_pkg::*;

    // candidate divisor carries one extra bit so base + 1 fits
    localparam int unsigned CAND_W = DIV_W + 1;

    // sequencer codes
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MUL_BASE = 3'd1;   // baud * ratio into divider
    localparam logic [2:0] S_DIV_BASE = 3'd2;   // clock / (baud * ratio)
    localparam logic [2:0] S_CHK_BASE = 3'd3;   // skip zero or oversized base
    localparam logic [2:0] S_MUL_CAND = 3'd4;   // candidate * ratio into divider
    localparam logic [2:0] S_DIV_CAND = 3'd5;   // achieved rate
    localparam logic [2:0] S_CMP_CAND = 3'd6;   // error compare, keep best
    localparam logic [2:0] S_DONE     = 3'd7;   // hand result to output stage

    // control state
    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OSR_W-1:0]  code_reg, code_next;
    logic              second_reg, second_next;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;
    word_t             clock_hz_reg, clock_hz_next;

    // datapath
    word_t             baud_reg, baud_next;
    logic [CAND_W-1:0] cand_reg, cand_next;
    logic [PROD_W-1:0] dvs_reg, dvs_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    word_t             q_reg, q_next;
    word_t             min_err_reg, min_err_next;
    logic [OSR_W-1:0]  best_code_reg, best_code_next;
    logic [DIV_W-1:0]  best_div_reg, best_div_next;
    logic [OSR_W-1:0]  osr_out_reg, osr_out_next;
    logic [DIV_W-1:0]  div_out_reg, div_out_next;

    // shared multiplier: one operand times the oversampling ratio
    logic [RATIO_W-1:0] ratio;
    word_t              mul_a;
    logic [PROD_W-1:0]  product;

    // shared divider step
    logic [PROD_W-1:0]  rem_sh;
    logic               rem_ge;
    logic [PROD_W-1:0]  rem_sub;

    word_t              err;
    logic               base_bad;
    logic               have_next_cand;

    assign ratio   = {1'b0, code_reg} + RATIO_W'(1);
    assign mul_a   = (state_reg == S_MUL_BASE) ? baud_reg
                                               : DATA_W'(cand_reg);
    assign product = PROD_W'(mul_a) * PROD_W'(ratio);

    assign rem_sh  = {rem_reg, q_reg[DATA_W-1]};
    assign rem_ge  = (rem_sh >= dvs_reg);
    assign rem_sub = rem_sh - dvs_reg;

    assign err      = (baud_reg > q_reg) ? (baud_reg - q_reg) : (q_reg - baud_reg);
    assign base_bad = (q_reg == '0) || (q_reg > DATA_W'(MAX_DIVISOR));
    assign have_next_cand = !second_reg && (cand_reg < CAND_W'(MAX_DIVISOR));

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign osr_code  = osr_out_reg;
    assign divisor   = div_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        code_next      = code_reg;
        second_next    = second_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        clock_hz_next  = clock_hz_reg;
        baud_next      = baud_reg;
        cand_next      = cand_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        min_err_next   = min_err_reg;
        best_code_next = best_code_reg;
        best_div_next  = best_div_reg;
        osr_out_next   = osr_out_reg;
        div_out_next   = div_out_reg;

        if (cfg_wr_en)
        begin
            clock_hz_next = cfg_wr_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    baud_next      = baud_rate;
                    code_next      = OSR_FIRST;
                    found_next     = 1'b0;
                    best_code_next = '0;
                    best_div_next  = '0;
                    min_err_next   = '0;
                    // a zero rate has no fit
                    state_next     = (baud_rate == '0) ? S_DONE : S_MUL_BASE;
                end
            end

            S_MUL_BASE, S_MUL_CAND:
            begin
                dvs_next   = product;
                q_next     = clock_hz_reg;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = (state_reg == S_MUL_BASE) ? S_DIV_BASE : S_DIV_CAND;
            end

            S_DIV_BASE, S_DIV_CAND:
            begin
                // restoring division, one quotient bit per cycle
                rem_next = rem_ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
                q_next   = {q_reg[DATA_W-2:0], rem_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    state_next = (state_reg == S_DIV_BASE) ? S_CHK_BASE : S_CMP_CAND;
                end
            end

            S_CHK_BASE:
            begin
                if (base_bad)
                begin
                    if (code_reg == OSR_LAST)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        code_next  = code_reg - OSR_W'(1);
                        state_next = S_MUL_BASE;
                    end
                end
                else
                begin
                    cand_next   = q_reg[CAND_W-1:0];
                    second_next = 1'b0;
                    state_next  = S_MUL_CAND;
                end
            end

            S_CMP_CAND:
            begin
                // strict compare so the first candidate wins a tie
                if (!found_reg || (err < min_err_reg))
                begin
                    found_next     = 1'b1;
                    min_err_next   = err;
                    best_code_next = code_reg;
                    best_div_next  = cand_reg[DIV_W-1:0];
                end
                if (have_next_cand)
                begin
                    cand_next   = cand_reg + CAND_W'(1);
                    second_next = 1'b1;
                    state_next  = S_MUL_CAND;
                end
                else if (code_reg == OSR_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    code_next  = code_reg - OSR_W'(1);
                    state_next = S_MUL_BASE;
                end
            end

            S_DONE:
            begin
                // wait for a free output register
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    osr_out_next   = best_code_reg;
                    div_out_next   = best_div_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            code_reg      <= '0;
            second_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            clock_hz_reg  <= CLOCK_HZ_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            code_reg      <= code_next;
            second_reg    <= second_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            clock_hz_reg  <= clock_hz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        baud_reg      <= baud_next;
        cand_reg      <= cand_next;
        dvs_reg       <= dvs_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        min_err_reg   <= min_err_next;
        best_code_reg <= best_code_next;
        best_div_reg  <= best_div_next;
        osr_out_reg   <= osr_out_next;
        div_out_reg   <= div_out_next;
    end

`ifndef ASSERT_OFF
    // a taken request starts the search, or finishes at once for a zero rate
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MUL_BASE || state_reg == S_DONE))
        else $error("search did not start after request");

    // either both result fields are zero or neither is
    a_no_fit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((osr_code == '0) == (divisor == '0)))
        else $error("result fields disagree on fit");

    // a fitted code is never below the last searched code
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (osr_code != '0)) |-> (osr_code >= OSR_LAST))
        else $error("oversampling code out of range");

    // a kept candidate always has a nonzero divisor within the limit
    a_best: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_div_reg != '0 && DATA_W'(best_div_reg) <= DATA_W'(MAX_DIVISOR)))
        else $error("kept divisor out of range");

    // the divider counter only moves while dividing
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (state_reg == S_DIV_BASE || state_reg == S_DIV_CAND
                             || $past(state_reg == S_DIV_BASE || state_reg == S_DIV_CAND)))
        else $error("divider counter runs outside a division");
`endif

endmodule
